// ===== design/ledcc_pkg.sv =====
// ----------------------------------------------------------------------------
// ledcc_pkg
// Shared types, codes and constants of the LED column console glue block.
// ----------------------------------------------------------------------------
package ledcc_pkg;

  typedef enum logic [3:0] {
    OP_RAM_WR   = 4'd0,
    OP_RAM_RD   = 4'd1,
    OP_PORT1_WR = 4'd2,
    OP_PORT2_WR = 4'd3,
    OP_PORT1_RD = 4'd4,
    OP_T1_RD    = 4'd5,
    OP_FRAME    = 4'd6,
    OP_SND_G    = 4'd7,
    OP_SND_D    = 4'd8
  } op_e;

  localparam logic [7:0] PAD_MASK_B1  = 8'hf7;
  localparam logic [7:0] PAD_MASK_B3  = 8'hcf;
  localparam logic [7:0] PAD_MASK_B2  = 8'haf;
  localparam logic [7:0] PAD_MASK_B0  = 8'h6f;
  localparam logic [7:0] PAD_LOW_MASK = 8'hf8;
  localparam logic [7:0] PAD_BTN_SET  = 8'h0f;
  localparam logic [7:0] LATCH_FULL   = 8'hff;
  localparam logic [2:0] VBANK_SOUND  = 3'd6;
  localparam logic [1:0] RAM_BANK_RST = 2'd3;

  typedef logic [7:0][7:0] latch_arr_t;

  typedef struct packed {
    logic [3:0] op;
    logic [7:0] data;
    logic [7:0] pad;
  } item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        column_valid;
    logic [7:0]  column_x;
    logic [63:0] lit_column;
    logic        ea_line;
    logic [3:0]  sound_cmd;
    logic        sound_reset_valid;
    logic        sound_reset_asserted;
    logic [1:0]  dac_level;
  } result_t;

  function automatic logic [1:0] dac_lookup(input logic [1:0] pins);
    logic [1:0] lvl;
    case (pins)
      2'd0:    lvl = 2'd2;
      2'd1:    lvl = 2'd0;
      2'd2:    lvl = 2'd0;
      default: lvl = 2'd1;
    endcase
    return lvl;
  endfunction

  // bit row*8+i lit when bit 7-i of latch 7-row is clear
  function automatic logic [63:0] lit_map(input latch_arr_t lat);
    logic [63:0] lit;
    for (int row = 0; row < 8; row++) begin
      for (int i = 0; i < 8; i++) begin
        lit[row*8 + i] = ~lat[7 - row][7 - i];
      end
    end
    return lit;
  endfunction

endpackage

// ===== design/ledcc_ram.sv =====
// ----------------------------------------------------------------------------
// ledcc_ram
// Single-port external RAM with registered read data.
// ----------------------------------------------------------------------------
module ledcc_ram #(
  parameter int Depth = 1024,
  parameter int Aw    = 10
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic          re_i,
  input  logic [Aw-1:0] addr_i,
  input  logic [7:0]    wdata_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/ledcc_core.sv =====
// ----------------------------------------------------------------------------
// ledcc_core
// Console state registers and the per-item step logic producing one result.
// ----------------------------------------------------------------------------
module ledcc_core #(
  parameter int Columns = 256,
  parameter int Cw      = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                item_valid_i,
  input  logic                step_i,
  input  ledcc_pkg::item_t    item_i,
  input  logic [7:0]          ram_rdata_i,
  output logic [1:0]          bank_fwd_o,
  output ledcc_pkg::result_t  res_o
);

  localparam logic [Cw-1:0] ColLast = Cw'(Columns - 1);

  logic [1:0]            ram_bank_q, ram_bank_d;
  logic                  ea_q, ea_d;
  logic                  ven_q, ven_d;
  logic [2:0]            vbank_q, vbank_d;
  ledcc_pkg::latch_arr_t lat_q, lat_d;
  logic [Cw-1:0]         col_q, col_d;
  logic [1:0]            phase_q, phase_d;
  logic                  flag_q, flag_d;
  logic [3:0]            scmd_q, scmd_d;
  logic [1:0]            pins_q, pins_d;
  logic [7:0]            ctrl_byte;

  // bank as seen by the item that follows the one in this stage
  assign bank_fwd_o = (item_valid_i && item_i.op == ledcc_pkg::OP_PORT1_WR) ?
                      item_i.data[1:0] : ram_bank_q;

  always_comb begin
    ctrl_byte = item_i.pad | ledcc_pkg::PAD_BTN_SET;
    if (item_i.pad[1]) ctrl_byte = ctrl_byte & ledcc_pkg::PAD_MASK_B1;
    if (item_i.pad[3]) ctrl_byte = ctrl_byte & ledcc_pkg::PAD_MASK_B3;
    if (item_i.pad[2]) ctrl_byte = ctrl_byte & ledcc_pkg::PAD_MASK_B2;
    if (item_i.pad[0]) ctrl_byte = ctrl_byte & ledcc_pkg::PAD_MASK_B0;
    ctrl_byte = (ctrl_byte & ledcc_pkg::PAD_LOW_MASK) | {5'd0, ea_q, ram_bank_q};
  end

  always_comb begin
    ram_bank_d = ram_bank_q;
    ea_d       = ea_q;
    ven_d      = ven_q;
    vbank_d    = vbank_q;
    lat_d      = lat_q;
    col_d      = col_q;
    phase_d    = phase_q;
    flag_d     = flag_q;
    scmd_d     = scmd_q;
    pins_d     = pins_q;
    res_o      = '0;
    case (ledcc_pkg::op_e'(item_i.op))
      ledcc_pkg::OP_RAM_WR: begin
      end
      ledcc_pkg::OP_RAM_RD: begin
        res_o.read_data = ram_rdata_i;
        if (vbank_q >= 3'd1 && vbank_q <= 3'd5) begin
          lat_d[vbank_q] = ram_rdata_i;
        end
        if (vbank_q == ledcc_pkg::VBANK_SOUND) begin
          res_o.sound_reset_valid    = 1'b1;
          res_o.sound_reset_asserted = ~ram_rdata_i[0];
        end
      end
      ledcc_pkg::OP_PORT1_WR: begin
        ea_d       = item_i.data[2];
        ram_bank_d = item_i.data[1:0];
      end
      ledcc_pkg::OP_PORT2_WR: begin
        scmd_d = item_i.data[7:4];
        if (!ven_q && item_i.data[4]) begin
          res_o.column_valid = 1'b1;
          res_o.column_x     = 8'(col_q);
          res_o.lit_column   = ledcc_pkg::lit_map(lat_q);
          lat_d              = {8{ledcc_pkg::LATCH_FULL}};
          col_d              = (col_q == ColLast) ? '0 : col_q + 1'b1;
        end
        ven_d   = item_i.data[4];
        vbank_d = item_i.data[7:5];
      end
      ledcc_pkg::OP_PORT1_RD: begin
        res_o.read_data = ctrl_byte;
      end
      ledcc_pkg::OP_T1_RD: begin
        res_o.read_data = {7'd0, ~flag_q};
        flag_d          = 1'b0;
      end
      ledcc_pkg::OP_FRAME: begin
        if (phase_q == 2'd0) begin
          flag_d = 1'b1;
          col_d  = '0;
        end
        phase_d = phase_q + 2'd1;
      end
      ledcc_pkg::OP_SND_G: begin
        pins_d = {item_i.data[0], pins_q[0]};
      end
      ledcc_pkg::OP_SND_D: begin
        pins_d = {pins_q[1], item_i.data[0]};
      end
      default: begin
      end
    endcase
    res_o.ea_line   = ea_d;
    res_o.sound_cmd = scmd_d;
    res_o.dac_level = ledcc_pkg::dac_lookup(pins_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ram_bank_q <= ledcc_pkg::RAM_BANK_RST;
      ea_q       <= 1'b1;
      ven_q      <= 1'b0;
      vbank_q    <= '0;
      lat_q      <= '0;
      col_q      <= '0;
      phase_q    <= '0;
      flag_q     <= 1'b0;
      scmd_q     <= '0;
      pins_q     <= '0;
    end else if (step_i) begin
      ram_bank_q <= ram_bank_d;
      ea_q       <= ea_d;
      ven_q      <= ven_d;
      vbank_q    <= vbank_d;
      lat_q      <= lat_d;
      col_q      <= col_d;
      phase_q    <= phase_d;
      flag_q     <= flag_d;
      scmd_q     <= scmd_d;
      pins_q     <= pins_d;
    end
  end

endmodule

// ===== design/led_column_console_glue.sv =====
// ----------------------------------------------------------------------------
// led_column_console_glue
// Top level: input stage with RAM access, step logic, result register.
// ----------------------------------------------------------------------------
// Input stage (item, RAM read data), then result register. Throughput: one
// item per cycle unless out_ready_i stalls; the RAM port and result register
// take one access per cycle. in_ready_o stays high while results drain.
// Reset: asynchronous, clears control and console state; RAM holds garbage
// until written. No clearing pass.
module led_column_console_glue #(
  parameter int EXT_RAM_DEPTH = 1024,
  parameter int COLUMNS       = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [3:0]  operation_i,
  input  logic [7:0]  address_i,
  input  logic [7:0]  data_i,
  input  logic [7:0]  pad_state_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  read_data_o,
  output logic        column_valid_o,
  output logic [7:0]  column_x_o,
  output logic [63:0] lit_column_o,
  output logic        ea_line_o,
  output logic [3:0]  sound_cmd_o,
  output logic        sound_reset_valid_o,
  output logic        sound_reset_asserted_o,
  output logic [1:0]  dac_level_o
);

  localparam int Aw = $clog2(EXT_RAM_DEPTH);
  localparam int Cw = $clog2(COLUMNS);
  localparam logic [10:0] DepthW = 11'(EXT_RAM_DEPTH);

  logic               s1_valid_q;
  ledcc_pkg::item_t   s1_q;
  logic               out_valid_q;
  ledcc_pkg::result_t out_q;
  ledcc_pkg::result_t res;
  logic               advance, in_fire, step;
  logic [1:0]         bank_fwd;
  logic [10:0]        full_idx;
  logic [Aw-1:0]      ram_addr;
  logic [7:0]         ram_rdata;

  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;
  assign step       = s1_valid_q && advance;

  // bank offset plus address, wrapped to the RAM depth
  always_comb begin
    full_idx = {1'b0, bank_fwd, address_i};
    for (int k = 0; k < 3; k++) begin
      if (full_idx >= DepthW) full_idx = full_idx - DepthW;
    end
    ram_addr = full_idx[Aw-1:0];
  end

  ledcc_ram #(
    .Depth (EXT_RAM_DEPTH),
    .Aw    (Aw)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (in_fire && operation_i == ledcc_pkg::OP_RAM_WR),
    .re_i    (in_fire && operation_i == ledcc_pkg::OP_RAM_RD),
    .addr_i  (ram_addr),
    .wdata_i (data_i),
    .rdata_o (ram_rdata)
  );

  ledcc_core #(
    .Columns (COLUMNS),
    .Cw      (Cw)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (s1_valid_q),
    .step_i       (step),
    .item_i       (s1_q),
    .ram_rdata_i  (ram_rdata),
    .bank_fwd_o   (bank_fwd),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) s1_valid_q <= in_valid_i;
      if (advance) out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q.op   <= operation_i;
      s1_q.data <= data_i;
      s1_q.pad  <= pad_state_i;
    end
    if (step) begin
      out_q <= res;
    end
  end

  assign out_valid_o            = out_valid_q;
  assign read_data_o            = out_q.read_data;
  assign column_valid_o         = out_q.column_valid;
  assign column_x_o             = out_q.column_x;
  assign lit_column_o           = out_q.lit_column;
  assign ea_line_o              = out_q.ea_line;
  assign sound_cmd_o            = out_q.sound_cmd;
  assign sound_reset_valid_o    = out_q.sound_reset_valid;
  assign sound_reset_asserted_o = out_q.sound_reset_asserted;
  assign dac_level_o            = out_q.dac_level;

`ifndef SYNTHESIS
  a_col_vs_sound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(column_valid_o && sound_reset_valid_o))
    else $error("column and sound reset in one item");

  a_lit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !column_valid_o) |-> (lit_column_o == 64'd0))
    else $error("lit column without emission");

  a_rst_assert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && sound_reset_asserted_o) |-> sound_reset_valid_o)
    else $error("sound reset level without valid");

  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !advance) |=> s1_valid_q)
    else $error("stalled item dropped");
`endif

endmodule
